// ----- hdl/constant_accel_ramp_step_top_assert.svh -----
// Assertion macros for the constant-acceleration ramp step block.
// CAR_ASSERT checks a property on the rising clock edge, held off in reset.
// CAR_ASSERT_IMP checks that an antecedent implies a consequent in the same cycle.
`ifndef CONSTANT_ACCEL_RAMP_STEP_TOP_ASSERT_SVH
`define CONSTANT_ACCEL_RAMP_STEP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CAR_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("ramp step assertion failed");
`define CAR_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ramp step implication failed");
`else
`define CAR_ASSERT(lbl, ck, rstn, prop)
`define CAR_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`endif
`endif

// ----- hdl/car_pkg.sv -----
// ----------------------------------------------------------------------------
// car_pkg
// Shared types and constants of the constant-acceleration ramp step.
// ----------------------------------------------------------------------------
`default_nettype none
package car_pkg;
	localparam int DATA_W     = 32;
	localparam int WIDE_W     = 64;
	localparam int ROOT_STEPS = 32;
	localparam int QUOT_W     = 35;
	localparam int DEN_W      = 33;
	localparam int DELTA_W    = 34;

	typedef enum logic [1:0] {
		REG_START = 2'd0,
		REG_LIMIT = 2'd1,
		REG_ACCEL = 2'd2,
		REG_DIR   = 2'd3
	} cfg_reg_t;

	// Travels alongside the square-root pipeline
	typedef struct packed {
		logic [DATA_W-1:0] cur;
		logic [DATA_W-1:0] a;
		logic [WIDE_W-1:0] l2;
		logic              pos;
		logic              zero;
		logic              rising;
	} side_t;

	// Travels alongside the divider pipeline
	typedef struct packed {
		logic [DATA_W-1:0] cur;
		logic              zero;
		logic              rising;
		logic              snap;
		logic              sat;
	} dside_t;
endpackage
`default_nettype wire

// ----- hdl/constant_accel_ramp_step_top.sv -----
// ----------------------------------------------------------------------------
// constant_accel_ramp_step_top
// One step of a constant-acceleration ramp toward a limit, Q16.16 values.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries current_value in; m_* returns next_value in m_tdata and the
//   at_limit flag in m_tuser. Registers are written through cfg_we,
//   cfg_index and cfg_wdata: 0 start, 1 limit, 2 accel, 3 direction.
//   Write them only while no transfer is in flight.
//   An input transfer passes to its result through 3 front
//   stages, 32 root stages, 3 square/numerator stages, 35 divider stages
//   and the output register. One item is taken per cycle unless held.
//   The whole pipeline advances together; it holds when the output register
//   is full and m_tready is low, so s_tready drops in that cycle and no
//   item is lost or repeated. Bubbles are not squeezed out during a hold.
//   Reset clears all valid bits and the registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "constant_accel_ramp_step_top_assert.svh"
module constant_accel_ramp_step_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] current_value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] next_value
	output logic [0:0]       m_tuser,   // [0] at_limit
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	logic [car_pkg::DATA_W-1:0] start_q, limit_q, accel_q;
	logic                       dir_q;
	logic                       en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			limit_q <= '0;
			accel_q <= '0;
			dir_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (car_pkg::cfg_reg_t'(cfg_index))
				car_pkg::REG_START: start_q <= cfg_wdata;
				car_pkg::REG_LIMIT: limit_q <= cfg_wdata;
				car_pkg::REG_ACCEL: accel_q <= cfg_wdata;
				car_pkg::REG_DIR:   dir_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic                       vf;
	logic [car_pkg::WIDE_W-1:0] argf;
	car_pkg::side_t             sidef;

	car_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(s_tvalid), .cur_in(s_tdata),
		.start_val(start_q), .limit_val(limit_q), .accel_val(accel_q), .dir(dir_q),
		.vld_out(vf), .arg_out(argf), .side_out(sidef)
	);

	logic                       vr;
	logic [car_pkg::DATA_W-1:0] root;
	car_pkg::side_t             sider;

	car_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vf), .rad_in(argf), .side_in(sidef),
		.vld_out(vr), .root_out(root), .side_out(sider)
	);

	// Speed: accelerating s = root + a, decelerating s = root - a (snap at <= 0)
	logic [car_pkg::DATA_W:0]   s_sum;
	logic                       vld_s1, vld_s2, vld_s3;
	logic [car_pkg::DATA_W-1:0] m_s1;
	car_pkg::side_t             side_s1, side_s2, side_s3;
	logic                       snap_s1, sat_s1, snap_s2, sat_s2, snap_s3, sat_s3;
	logic [car_pkg::WIDE_W-1:0] sq_s2, num_s3;
	logic [car_pkg::DEN_W-1:0]  den_c, den_s3;
	logic [car_pkg::WIDE_W-1:0] num_c;

	always_comb begin
		if (sider.pos)
			s_sum = {1'b0, root} + {1'b0, sider.a};
		else
			s_sum = {1'b0, root} - {1'b0, sider.a};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= s_sum[car_pkg::DATA_W-1:0];
			side_s1 <= sider;
			snap_s1 <= !sider.pos && (root <= sider.a);
			sat_s1  <= sider.pos && s_sum[car_pkg::DATA_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2   <= car_pkg::WIDE_W'(m_s1) * car_pkg::WIDE_W'(m_s1);
			side_s2 <= side_s1;
			snap_s2 <= snap_s1;
			sat_s2  <= sat_s1;
		end
	end

	always_comb begin
		den_c = {side_s2.a, 1'b0};
		if (side_s2.pos)
			num_c = sq_s2;
		else
			num_c = (sq_s2 >= side_s2.l2) ? '0 : side_s2.l2 - sq_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3  <= num_c;
			den_s3  <= den_c;
			side_s3 <= side_s2;
			snap_s3 <= snap_s2;
			// quotient would reach 2^QUOT_W: well past the saturation point
			sat_s3  <= sat_s2 ||
				(car_pkg::DEN_W'(num_c[car_pkg::WIDE_W-1:car_pkg::QUOT_W]) >= den_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vr;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	car_pkg::dside_t            dside_in, dside;
	logic                       vd;
	logic [car_pkg::QUOT_W-1:0] quot;

	always_comb begin
		dside_in.cur    = side_s3.cur;
		dside_in.zero   = side_s3.zero;
		dside_in.rising = side_s3.rising;
		dside_in.snap   = snap_s3;
		dside_in.sat    = sat_s3;
	end

	car_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_s3), .num_in(num_s3), .den_in(den_s3), .side_in(dside_in),
		.vld_out(vd), .quot_out(quot), .side_out(dside)
	);

	// Step from start, clamp at the limit; with zero accel the current value passes
	localparam logic [car_pkg::DELTA_W-1:0] STEP_SAT = car_pkg::DELTA_W'(1) << 33;
	logic [car_pkg::DELTA_W-1:0] delta;
	logic [35:0]                 nxt, lim36;
	logic [31:0]                 nv;
	logic                        at;

	always_comb begin
		if (dside.sat || quot > car_pkg::QUOT_W'(STEP_SAT))
			delta = STEP_SAT;
		else
			delta = quot[car_pkg::DELTA_W-1:0];
		lim36 = {{4{limit_q[31]}}, limit_q};
		if (dside.rising)
			nxt = {{4{start_q[31]}}, start_q} + {2'b00, delta};
		else
			nxt = {{4{start_q[31]}}, start_q} - {2'b00, delta};
		priority if (dside.zero) begin
			nv = dside.cur;
			at = 1'b0;
		end else if (dside.snap) begin
			nv = limit_q;
			at = 1'b1;
		end else if (dside.rising ? ($signed(nxt) >= $signed(lim36))
			: ($signed(nxt) <= $signed(lim36))) begin
			nv = limit_q;
			at = 1'b1;
		end else begin
			nv = nxt[31:0];
			at = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (en)
			m_tvalid <= vd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata    <= nv;
			m_tuser[0] <= at;
		end
	end

	logic out_rise_free;
	assign out_rise_free = m_tvalid && !m_tuser[0] && accel_q != '0 && !dir_q;

	`CAR_ASSERT_IMP(a_zero_accel_free, clk, arst_n, m_tvalid && accel_q == '0, !m_tuser[0])
	`CAR_ASSERT_IMP(a_limit_value, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == limit_q)
	`CAR_ASSERT_IMP(a_rise_below, clk, arst_n, out_rise_free, $signed(m_tdata) < $signed(limit_q))
	`CAR_ASSERT(a_stall_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
endmodule
`default_nettype wire

// ----- hdl/car_front.sv -----
// ----------------------------------------------------------------------------
// car_front
// Distance, span and magnitude stage, products, root argument (3 stages).
// ----------------------------------------------------------------------------
`default_nettype none
module car_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        vld_in,
	input  wire logic [car_pkg::DATA_W-1:0]  cur_in,
	input  wire logic [car_pkg::DATA_W-1:0]  start_val,
	input  wire logic [car_pkg::DATA_W-1:0]  limit_val,
	input  wire logic [car_pkg::DATA_W-1:0]  accel_val,
	input  wire logic                        dir,
	output logic                             vld_out,
	output logic [car_pkg::WIDE_W-1:0]       arg_out,
	output car_pkg::side_t                   side_out
);
	logic                        rising;
	logic [car_pkg::DATA_W:0]    prog, span, aneg;
	logic [car_pkg::DATA_W-1:0]  d_c, sp_c, a_c;
	logic [car_pkg::WIDE_W-1:0]  pd, ps;

	logic                        vld_s1, vld_s2, vld_s3;
	logic [car_pkg::DATA_W-1:0]  cur_s1, d_s1, sp_s1, a_s1;
	logic                        pos_s1, zero_s1, rising_s1;
	logic [car_pkg::WIDE_W-1:0]  t_s2;
	car_pkg::side_t              side_s2, side_s3;
	logic [car_pkg::WIDE_W-1:0]  arg_s3;

	always_comb begin
		rising = !dir;
		if (rising) begin
			prog = {cur_in[31], cur_in} - {start_val[31], start_val};
			span = {limit_val[31], limit_val} - {start_val[31], start_val};
		end else begin
			prog = {start_val[31], start_val} - {cur_in[31], cur_in};
			span = {start_val[31], start_val} - {limit_val[31], limit_val};
		end
		d_c  = (!prog[car_pkg::DATA_W] && prog != '0) ? prog[car_pkg::DATA_W-1:0] : '0;
		sp_c = (!span[car_pkg::DATA_W] && span != '0) ? span[car_pkg::DATA_W-1:0] : '0;
		aneg = (car_pkg::DATA_W+1)'(0) - {accel_val[31], accel_val};
		a_c  = accel_val[31] ? aneg[car_pkg::DATA_W-1:0] : accel_val;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_s1    <= cur_in;
			d_s1      <= d_c;
			sp_s1     <= sp_c;
			a_s1      <= a_c;
			pos_s1    <= !accel_val[31] && accel_val != '0;
			zero_s1   <= accel_val == '0;
			rising_s1 <= rising;
		end
	end

	assign pd = car_pkg::WIDE_W'(a_s1) * car_pkg::WIDE_W'(d_s1);
	assign ps = car_pkg::WIDE_W'(a_s1) * car_pkg::WIDE_W'(sp_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2           <= {pd[car_pkg::WIDE_W-2:0], 1'b0};
			side_s2.cur    <= cur_s1;
			side_s2.a      <= a_s1;
			side_s2.l2     <= {ps[car_pkg::WIDE_W-2:0], 1'b0};
			side_s2.pos    <= pos_s1;
			side_s2.zero   <= zero_s1;
			side_s2.rising <= rising_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s2.pos)
				arg_s3 <= t_s2;
			else
				arg_s3 <= (t_s2 >= side_s2.l2) ? '0 : side_s2.l2 - t_s2;
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign vld_out  = vld_s3;
	assign arg_out  = arg_s3;
	assign side_out = side_s3;
endmodule
`default_nettype wire

// ----- hdl/car_sqrt.sv -----
// ----------------------------------------------------------------------------
// car_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module car_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        vld_in,
	input  wire logic [car_pkg::WIDE_W-1:0]  rad_in,
	input  car_pkg::side_t                   side_in,
	output logic                             vld_out,
	output logic [car_pkg::DATA_W-1:0]       root_out,
	output car_pkg::side_t                   side_out
);
	localparam int N = car_pkg::ROOT_STEPS;

	logic                        vld_s  [0:N];
	logic [car_pkg::WIDE_W-1:0]  rad_s  [0:N];
	logic [car_pkg::WIDE_W-1:0]  root_s [0:N];
	car_pkg::side_t              side_s [0:N];

	assign vld_s[0]  = vld_in;
	assign rad_s[0]  = rad_in;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [car_pkg::WIDE_W-1:0] BITV =
			car_pkg::WIDE_W'(1) << (car_pkg::WIDE_W - 2 - 2 * k);
		logic [car_pkg::WIDE_W-1:0] trial;
		assign trial = root_s[k] + BITV;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rad_s[k] >= trial) begin
					rad_s[k+1]  <= rad_s[k] - trial;
					root_s[k+1] <= (root_s[k] >> 1) + BITV;
				end else begin
					rad_s[k+1]  <= rad_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
				side_s[k+1] <= side_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end
	end

	assign vld_out  = vld_s[N];
	assign root_out = root_s[N][car_pkg::DATA_W-1:0];
	assign side_out = side_s[N];
endmodule
`default_nettype wire

// ----- hdl/car_div.sv -----
// ----------------------------------------------------------------------------
// car_div
// Pipelined restoring divider, one quotient bit per stage. The numerator
// is known to be below den * 2^QUOT_W unless the item is flagged saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module car_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        vld_in,
	input  wire logic [car_pkg::WIDE_W-1:0]  num_in,
	input  wire logic [car_pkg::DEN_W-1:0]   den_in,
	input  car_pkg::dside_t                  side_in,
	output logic                             vld_out,
	output logic [car_pkg::QUOT_W-1:0]       quot_out,
	output car_pkg::dside_t                  side_out
);
	localparam int N  = car_pkg::QUOT_W;
	localparam int RW = car_pkg::DEN_W + 1;

	logic                        vld_s  [0:N];
	logic [RW-1:0]               rem_s  [0:N];
	logic [N-1:0]                low_s  [0:N];
	logic [N-1:0]                quot_s [0:N];
	logic [car_pkg::DEN_W-1:0]   den_s  [0:N];
	car_pkg::dside_t             side_s [0:N];

	assign vld_s[0]  = vld_in;
	assign rem_s[0]  = RW'(num_in[car_pkg::WIDE_W-1:N]);
	assign low_s[0]  = num_in[N-1:0];
	assign quot_s[0] = '0;
	assign den_s[0]  = den_in;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [RW-1:0] tmp;
		assign tmp = {rem_s[i][RW-2:0], low_s[i][N-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (tmp >= RW'(den_s[i])) begin
					rem_s[i+1]  <= tmp - RW'(den_s[i]);
					quot_s[i+1] <= {quot_s[i][N-2:0], 1'b1};
				end else begin
					rem_s[i+1]  <= tmp;
					quot_s[i+1] <= {quot_s[i][N-2:0], 1'b0};
				end
				low_s[i+1]  <= {low_s[i][N-2:0], 1'b0};
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end
	end

	assign vld_out  = vld_s[N];
	assign quot_out = quot_s[N];
	assign side_out = side_s[N];
endmodule
`default_nettype wire
